// ----- rtl/tha_pkg.sv -----
// Shared types and codes for the typed handle table allocator.
// No dependencies; imported by the top level and the checker.
package tha_pkg;

    // Operation codes carried on the op port
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_GET     = 2'd2,
        OP_FIND    = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_LOOKUP,
        S_CHECK,
        S_SCAN
    } state_t;

    localparam int HANDLE_W = 8;
    localparam int TYPE_W   = 3;
    localparam int CTRL_W   = 16;

    // One table entry as kept in the slot memory
    typedef struct packed {
        logic [TYPE_W-1:0]   stype;
        logic [HANDLE_W-1:0] sparent;
        logic [CTRL_W-1:0]   sctrl;
    } slot_t;

endpackage

// ----- rtl/typed_handle_table_allocator.sv -----
// Typed handle table: first-free allocate, release with one-level child sweep of windows,
// get by handle and find by parent and control id. Depends on tha_pkg.
// The table uses min(TABLE_ENTRIES,255) entries; each item gives one word.
// A window release shows its word first, then stays busy while the slot
// memory is swept one entry per cycle through one compare.
// Throughput is one item at a time; the receiver cannot stall the done strobe.
// Reset clears all valid bits at once; win_reg resets to 1.
module typed_handle_table_allocator
    import tha_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [TYPE_W-1:0]   entry_type,
    input  logic                any_type,
    input  logic [HANDLE_W-1:0] parent,
    input  logic [CTRL_W-1:0]   control_id,
    input  logic                cfg_we,
    input  logic [TYPE_W-1:0]   cfg_wdata,
    output logic                done,
    output logic                ok,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [TYPE_W-1:0]   type_out,
    output logic [HANDLE_W-1:0] parent_out
);

    localparam int USABLE = (TABLE_ENTRIES < 255) ? TABLE_ENTRIES : 255;
    localparam int IDX_W  = $clog2(USABLE);
    localparam int CNT_W  = $clog2(USABLE + 1);
    localparam logic [CNT_W-1:0]    USABLE_C = CNT_W'(USABLE);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(USABLE - 1);
    localparam logic [HANDLE_W-1:0] USABLE_H = HANDLE_W'(USABLE);

    // Control state
    state_t              state_reg, state_next;
    logic [USABLE-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [TYPE_W-1:0]   win_reg;
    logic                done_reg, done_next;

    // Captured item and pipeline payload
    op_t                 op_reg, op_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [TYPE_W-1:0]   etype_reg, etype_next;
    logic                any_reg, any_next;
    logic [HANDLE_W-1:0] key_reg, key_next;
    logic [CTRL_W-1:0]   ctrl_reg, ctrl_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                ok_reg, ok_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic [TYPE_W-1:0]   tout_reg, tout_next;
    logic [HANDLE_W-1:0] pout_reg, pout_next;

    // Slot memory
    slot_t               mem [USABLE];
    slot_t               rd_reg;
    slot_t               wr_data;
    logic                mem_we;
    logic [IDX_W-1:0]    rd_idx;

    logic                accept;
    logic [IDX_W-1:0]    sidx;
    logic [HANDLE_W-1:0] hm1;
    logic [IDX_W-1:0]    hidx;
    logic                in_range;
    logic                chk_hit;
    logic                is_window;
    logic                scan_match;
    logic                scan_last;

    assign accept    = start && (state_reg == S_IDLE);
    assign sidx      = scan_reg[IDX_W-1:0];
    assign hm1       = handle_reg - HANDLE_W'(1);
    assign hidx      = hm1[IDX_W-1:0];
    assign in_range  = (handle_reg != '0) && (handle_reg <= USABLE_H);
    assign chk_hit   = in_range && valid_reg[hidx]
                       && ((op_reg == OP_RELEASE) || any_reg || (rd_reg.stype == etype_reg));
    assign is_window = (rd_reg.stype == win_reg);
    assign scan_match = pend_reg && valid_reg[pidx_reg] && (rd_reg.sparent == key_reg)
                        && ((op_reg != OP_FIND) || (rd_reg.sctrl == ctrl_reg));
    assign scan_last = pend_reg && (pidx_reg == LAST_IDX);
    assign rd_idx    = (state_reg == S_LOOKUP) ? hidx : sidx;
    assign wr_data   = '{stype: etype_reg, sparent: key_reg, sctrl: ctrl_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_ALLOC: state_next = S_ALLOC;
                        OP_FIND:  state_next = S_SCAN;
                        default:  state_next = S_LOOKUP;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (!valid_reg[sidx] || (sidx == LAST_IDX))
                    state_next = S_IDLE;
            end
            S_LOOKUP: state_next = S_CHECK;
            S_CHECK:
            begin
                if ((op_reg == OP_RELEASE) && chk_hit && is_window)
                    state_next = S_SCAN;
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (((op_reg == OP_FIND) && scan_match) || scan_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result word
    always_comb
    begin
        valid_next  = valid_reg;
        scan_next   = scan_reg;
        pend_next   = 1'b0;
        pidx_next   = sidx;
        mem_we      = 1'b0;
        op_next     = op_reg;
        handle_next = handle_reg;
        etype_next  = etype_reg;
        any_next    = any_reg;
        key_next    = key_reg;
        ctrl_next   = ctrl_reg;
        done_next   = 1'b0;
        ok_next     = 1'b0;
        hout_next   = '0;
        tout_next   = '0;
        pout_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                // Capture the item
                if (accept)
                begin
                    op_next     = op_t'(op);
                    handle_next = handle;
                    etype_next  = entry_type;
                    any_next    = any_type;
                    key_next    = parent;
                    ctrl_next   = control_id;
                    scan_next   = '0;
                end
            end
            S_ALLOC:
            begin
                // Take the first free slot, else advance
                if (!valid_reg[sidx])
                begin
                    valid_next[sidx] = 1'b1;
                    mem_we    = 1'b1;
                    done_next = 1'b1;
                    ok_next   = 1'b1;
                    hout_next = HANDLE_W'(sidx) + HANDLE_W'(1);
                    tout_next = etype_reg;
                    pout_next = key_reg;
                end
                else if (sidx == LAST_IDX)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_LOOKUP:
            begin
                // Memory read of the addressed slot is in flight
            end
            S_CHECK:
            begin
                done_next = 1'b1;
                if (chk_hit)
                begin
                    ok_next   = 1'b1;
                    hout_next = handle_reg;
                    tout_next = rd_reg.stype;
                    pout_next = rd_reg.sparent;
                    if (op_reg == OP_RELEASE)
                    begin
                        valid_next[hidx] = 1'b0;
                        // Sweep children of a window
                        key_next  = handle_reg;
                        scan_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue the next read
                if (scan_reg < USABLE_C)
                begin
                    pend_next = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end
                // Compare the returned entry
                if (op_reg == OP_FIND)
                begin
                    if (scan_match)
                    begin
                        pend_next = 1'b0;
                        done_next = 1'b1;
                        ok_next   = 1'b1;
                        hout_next = HANDLE_W'(pidx_reg) + HANDLE_W'(1);
                        tout_next = rd_reg.stype;
                        pout_next = rd_reg.sparent;
                    end
                    else if (scan_last)
                    begin
                        done_next = 1'b1;
                    end
                end
                else if (scan_match)
                begin
                    valid_next[pidx_reg] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            win_reg   <= TYPE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
                win_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        handle_reg <= handle_next;
        etype_reg  <= etype_next;
        any_reg    <= any_next;
        key_reg    <= key_next;
        ctrl_reg   <= ctrl_next;
        pidx_reg   <= pidx_next;
        ok_reg     <= ok_next;
        hout_reg   <= hout_next;
        tout_reg   <= tout_next;
        pout_reg   <= pout_next;
    end

    // Slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[sidx] <= wr_data;
        rd_reg <= mem[rd_idx];
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign handle_out = hout_reg;
    assign type_out   = tout_reg;
    assign parent_out = pout_reg;

endmodule

// ----- rtl/tha_checker.sv -----
// Port-level checks for the typed handle table allocator.
// Depends on tha_pkg; bound to typed_handle_table_allocator below.
module tha_checker
    import tha_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                ok,
    input logic [HANDLE_W-1:0] handle_out,
    input logic [TYPE_W-1:0]   type_out,
    input logic [HANDLE_W-1:0] parent_out
);

    // A failed word carries all-zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (handle_out == '0 && type_out == '0 && parent_out == '0))
        else $error("failed word has nonzero fields");

    // A successful word names a real handle
    a_ok_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (handle_out != '0))
        else $error("successful word with null handle");

    // An accepted item holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // No word appears the cycle after idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !done)
        else $error("word without a pending item");

    // At most one word per item, never two in a row
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back words");

endmodule

bind typed_handle_table_allocator tha_checker u_tha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .ok         (ok),
    .handle_out (handle_out),
    .type_out   (type_out),
    .parent_out (parent_out)
);
